/* rtl/core/dfi_pkg.sv */
// ----------------------------------------------------------------------------
// dfi_pkg
// Shared types, phase codes and symbol tables for the fixed-Huffman decoder.
// ----------------------------------------------------------------------------
package dfi_pkg;

    localparam int WindowDepth  = 32768;
    localparam int PositionBits = 25;
    localparam int CapBits      = 25;
    localparam logic [CapBits-1:0] CapReset = 25'd65536;

    typedef enum logic [2:0] {
        PH_LITLEN     = 3'd0,
        PH_LEN_EXTRA  = 3'd1,
        PH_DIST       = 3'd2,
        PH_DIST_EXTRA = 3'd3,
        PH_COPY       = 3'd4,
        PH_STOP       = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        ACT_BIT     = 2'd0,
        ACT_DRAIN   = 2'd1,
        ACT_RESTART = 2'd2,
        ACT_NONE    = 2'd3
    } t_action;

    localparam logic [2:0] ST_RUN       = 3'd0;
    localparam logic [2:0] ST_EOB       = 3'd1;
    localparam logic [2:0] ST_BAD_LIT   = 3'd2;
    localparam logic [2:0] ST_BAD_DIST  = 3'd3;
    localparam logic [2:0] ST_TOO_FAR   = 3'd4;
    localparam logic [2:0] ST_FULL      = 3'd5;

    // history write request from the decoder to the window
    typedef struct packed {
        logic       wr_en;
        logic [7:0] wr_byte;
    } t_hist_req;

    function automatic logic [8:0] len_base(input logic [4:0] idx);
        case (idx)
            5'd0: return 9'd3;    5'd1: return 9'd4;    5'd2: return 9'd5;
            5'd3: return 9'd6;    5'd4: return 9'd7;    5'd5: return 9'd8;
            5'd6: return 9'd9;    5'd7: return 9'd10;   5'd8: return 9'd11;
            5'd9: return 9'd13;   5'd10: return 9'd15;  5'd11: return 9'd17;
            5'd12: return 9'd19;  5'd13: return 9'd23;  5'd14: return 9'd27;
            5'd15: return 9'd31;  5'd16: return 9'd35;  5'd17: return 9'd43;
            5'd18: return 9'd51;  5'd19: return 9'd59;  5'd20: return 9'd67;
            5'd21: return 9'd83;  5'd22: return 9'd99;  5'd23: return 9'd115;
            5'd24: return 9'd131; 5'd25: return 9'd163; 5'd26: return 9'd195;
            5'd27: return 9'd227; 5'd28: return 9'd258;
            default: return 9'd3;
        endcase
    endfunction

    function automatic logic [3:0] len_extra(input logic [4:0] idx);
        if (idx < 5'd8 || idx == 5'd28) return 4'd0;
        return 4'((idx - 5'd4) >> 2);
    endfunction

    function automatic logic [15:0] dist_base(input logic [4:0] code);
        case (code)
            5'd0: return 16'd1;      5'd1: return 16'd2;      5'd2: return 16'd3;
            5'd3: return 16'd4;      5'd4: return 16'd5;      5'd5: return 16'd7;
            5'd6: return 16'd9;      5'd7: return 16'd13;     5'd8: return 16'd17;
            5'd9: return 16'd25;     5'd10: return 16'd33;    5'd11: return 16'd49;
            5'd12: return 16'd65;    5'd13: return 16'd97;    5'd14: return 16'd129;
            5'd15: return 16'd193;   5'd16: return 16'd257;   5'd17: return 16'd385;
            5'd18: return 16'd513;   5'd19: return 16'd769;   5'd20: return 16'd1025;
            5'd21: return 16'd1537;  5'd22: return 16'd2049;  5'd23: return 16'd3073;
            5'd24: return 16'd4097;  5'd25: return 16'd6145;  5'd26: return 16'd8193;
            5'd27: return 16'd12289; 5'd28: return 16'd16385; 5'd29: return 16'd24577;
            default: return 16'd1;
        endcase
    endfunction

    function automatic logic [3:0] dist_extra(input logic [4:0] code);
        if (code < 5'd4) return 4'd0;
        return 4'((code >> 1) - 5'd1);
    endfunction

endpackage

/* rtl/core/dfi_if.sv */
// ----------------------------------------------------------------------------
// dfi interfaces
// Valid/ready channels for requests, results and the capacity register.
// ----------------------------------------------------------------------------
interface dfi_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic       in_bit;
    modport source (output valid, action, in_bit, input ready);
    modport sink   (input valid, action, in_bit, output ready);
endinterface

interface dfi_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        out_valid;
    logic        bit_accepted;
    logic        copy_pending;
    logic [2:0]  status;
    logic [24:0] bytes_written;
    modport source (output valid, out_byte, out_valid, bit_accepted, copy_pending,
                    status, bytes_written, input ready);
    modport sink   (input valid, out_byte, out_valid, bit_accepted, copy_pending,
                    status, bytes_written, output ready);
endinterface

interface dfi_cfg_if;
    logic        valid;
    logic        ready;
    logic [24:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

/* rtl/core/dfi_window.sv */
// ----------------------------------------------------------------------------
// dfi_window
// History memory: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module dfi_window
    import dfi_pkg::*;
#(
    parameter int WINDOW_DEPTH = WindowDepth
) (
    input  logic                            i_clk,
    input  t_hist_req                       i_req,
    input  logic [$clog2(WINDOW_DEPTH)-1:0] i_wr_addr,
    input  logic [$clog2(WINDOW_DEPTH)-1:0] i_rd_addr,
    output logic [7:0]                      o_rd_data
);
    logic [7:0] r_mem [WINDOW_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_wr_addr] <= i_req.wr_byte;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end
endmodule

/* rtl/core/dfi_decoder.sv */
// ----------------------------------------------------------------------------
// dfi_decoder
// Bit-level decode state and copy engine around the history window.
// ----------------------------------------------------------------------------
module dfi_decoder
    import dfi_pkg::*;
#(
    parameter int WINDOW_DEPTH  = WindowDepth,
    parameter int POSITION_BITS = PositionBits
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_go,
    input  logic [1:0]                      i_action,
    input  logic                            i_bit,
    input  logic [CapBits-1:0]              i_cap,
    input  logic [7:0]                      i_hist_byte,
    output t_hist_req                       o_hist_req,
    output logic [$clog2(WINDOW_DEPTH)-1:0] o_wr_addr,
    output logic [$clog2(WINDOW_DEPTH)-1:0] o_rd_addr,
    output logic                            o_copy_step,
    output logic [7:0]                      o_lit_byte,
    output logic                            o_out_valid,
    output logic                            o_bit_acc,
    output logic                            o_copy_pending,
    output logic [2:0]                      o_status,
    output logic [24:0]                     o_bytes
);
    localparam int AW = $clog2(WINDOW_DEPTH);

    t_phase                   r_phase, n_phase;
    logic [8:0]               r_shift, n_shift;
    logic [3:0]               r_cnt, n_cnt;
    logic [8:0]               r_sym, n_sym;
    logic [12:0]              r_ext, n_ext;
    logic [3:0]               r_ecnt, n_ecnt;
    logic [8:0]               r_len, n_len;
    logic [15:0]              r_dist, n_dist;
    logic [POSITION_BITS-1:0] r_pos, n_pos;
    logic [2:0]               r_st, n_st;
    logic [AW-1:0]            r_src, n_src;

    logic [8:0]  sh9;
    logic [4:0]  sh5, lidx;
    logic [12:0] ext_or;
    logic [16:0] dsum;
    logic        put, acc;
    logic [7:0]  pbyte;
    logic [3:0]  need;

    // distance one: byte written now is the next byte read
    logic       r_fwd;
    logic [7:0] r_fwd_byte, cur_hist;

    function automatic logic [4:0] lix(input logic [8:0] s);
        logic [8:0] t;
        t = s - 9'd257;
        return (t >= 9'd29) ? 5'(t - 9'd29) : t[4:0];
    endfunction

    always_comb begin
        n_phase = r_phase; n_shift = r_shift; n_cnt = r_cnt; n_sym = r_sym;
        n_ext = r_ext; n_ecnt = r_ecnt; n_len = r_len; n_dist = r_dist;
        n_pos = r_pos; n_st = r_st; n_src = r_src;
        put = 1'b0; acc = 1'b0; pbyte = '0;
        o_copy_step = 1'b0;
        sh9 = {r_shift[7:0], i_bit};
        sh5 = {r_shift[3:0], i_bit};
        ext_or = r_ext | (13'(i_bit) << r_ecnt);
        lidx = '0; need = '0; dsum = '0;
        if (i_action == ACT_RESTART) begin
            n_phase = PH_LITLEN; n_shift = '0; n_cnt = '0; n_sym = '0; n_ext = '0;
            n_ecnt = '0; n_len = '0; n_dist = '0; n_pos = '0; n_st = ST_RUN;
        end else if (i_action != ACT_NONE) begin
            if (r_st == ST_RUN && {{(32-POSITION_BITS){1'b0}}, r_pos} >=
                    {7'd0, i_cap}) begin
                n_st = ST_FULL; n_phase = PH_STOP; n_len = '0;
            end else if (r_st == ST_RUN) begin
                if (i_action == ACT_BIT && r_phase != PH_COPY) begin
                    acc = 1'b1;
                    unique case (r_phase)
                        PH_LITLEN: begin
                            n_shift = sh9; n_cnt = r_cnt + 4'd1;
                            if (n_cnt == 4'd7 && sh9 <= 9'd23) begin
                                n_shift = '0; n_cnt = '0;
                                if (sh9 == 9'd0) begin
                                    n_st = ST_EOB; n_phase = PH_STOP; n_len = '0;
                                end else begin
                                    n_sym = 9'd256 + sh9;
                                end
                            end else if (n_cnt == 4'd8 && sh9 >= 9'd48 &&
                                    sh9 <= 9'd191) begin
                                n_shift = '0; n_cnt = '0; put = 1'b1;
                                pbyte = 8'(sh9 - 9'd48);
                            end else if (n_cnt == 4'd8 && sh9 >= 9'd192 &&
                                    sh9 <= 9'd199) begin
                                n_shift = '0; n_cnt = '0;
                                n_sym = 9'd280 + sh9 - 9'd192;
                                if (n_sym > 9'd285) begin
                                    n_st = ST_BAD_LIT; n_phase = PH_STOP; n_len = '0;
                                end
                            end else if (n_cnt >= 4'd9) begin
                                n_shift = '0; n_cnt = '0;
                                if (sh9 >= 9'd400) begin
                                    put = 1'b1; pbyte = 8'(sh9 - 9'd256);
                                end else begin
                                    n_st = ST_BAD_LIT; n_phase = PH_STOP; n_len = '0;
                                end
                            end
                            // new length symbol
                            if (n_sym != r_sym && n_phase == PH_LITLEN && !put) begin
                                n_ext = '0; n_ecnt = '0;
                                lidx = lix(n_sym);
                                if (len_extra(lidx) == 4'd0) begin
                                    n_len = len_base(lidx); n_phase = PH_DIST;
                                end else begin
                                    n_phase = PH_LEN_EXTRA;
                                end
                            end
                        end
                        PH_LEN_EXTRA: begin
                            n_ext = ext_or; n_ecnt = r_ecnt + 4'd1;
                            lidx = lix(r_sym);
                            if (n_ecnt >= len_extra(lidx)) begin
                                n_len = len_base(lidx) + ext_or[8:0];
                                n_shift = '0; n_cnt = '0; n_phase = PH_DIST;
                            end
                        end
                        PH_DIST: begin
                            n_shift = {4'd0, sh5}; n_cnt = r_cnt + 4'd1;
                            if (n_cnt >= 4'd5) begin
                                n_sym = {4'd0, sh5}; n_shift = '0; n_cnt = '0;
                                n_ext = '0; n_ecnt = '0;
                                if (sh5 >= 5'd30) begin
                                    n_st = ST_BAD_DIST; n_phase = PH_STOP; n_len = '0;
                                end else if (dist_extra(sh5) == 4'd0) begin
                                    dsum = {1'b0, dist_base(sh5)};
                                end else begin
                                    n_phase = PH_DIST_EXTRA;
                                end
                            end
                        end
                        PH_DIST_EXTRA: begin
                            n_ext = ext_or; n_ecnt = r_ecnt + 4'd1;
                            need = dist_extra(r_sym[4:0]);
                            if (n_ecnt >= need) begin
                                dsum = {1'b0, dist_base(r_sym[4:0])} + {4'd0, ext_or};
                            end
                        end
                        default: ;
                    endcase
                    if (dsum != '0) begin
                        n_dist = dsum[15:0];
                        if ({{(32-POSITION_BITS){1'b0}}, r_pos} < 32'(dsum) ||
                                dsum > 17'(WINDOW_DEPTH)) begin
                            n_st = ST_TOO_FAR; n_phase = PH_STOP; n_len = '0;
                        end else begin
                            n_phase = PH_COPY;
                            n_src = AW'(r_pos[AW-1:0] - dsum[AW-1:0]);
                        end
                    end
                end else if (i_action == ACT_DRAIN && r_phase == PH_COPY) begin
                    put = 1'b1; o_copy_step = 1'b1; pbyte = cur_hist;
                    n_src = r_src + AW'(1);
                    if (r_len > 9'd0) n_len = r_len - 9'd1;
                    if (n_len == 9'd0) n_phase = PH_LITLEN;
                end
                if (put) n_pos = r_pos + POSITION_BITS'(1);
                if (n_st == ST_RUN && {{(32-POSITION_BITS){1'b0}}, n_pos} >=
                        {7'd0, i_cap}) begin
                    n_st = ST_FULL; n_phase = PH_STOP; n_len = '0;
                end
            end
        end
    end

    // read address: next source whenever a request is taken, else the current source
    always_comb begin
        if (i_go && o_copy_step) o_rd_addr = n_src;
        else if (i_go) o_rd_addr = n_src;
        else o_rd_addr = r_src;
    end

    assign cur_hist = r_fwd ? r_fwd_byte : i_hist_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LITLEN; r_shift <= '0; r_cnt <= '0; r_sym <= '0;
            r_ext <= '0; r_ecnt <= '0; r_len <= '0; r_dist <= '0; r_pos <= '0;
            r_st <= ST_RUN; r_src <= '0; r_fwd <= 1'b0;
        end else begin
            if (i_go) begin
                r_phase <= n_phase; r_shift <= n_shift; r_cnt <= n_cnt; r_sym <= n_sym;
                r_ext <= n_ext; r_ecnt <= n_ecnt; r_len <= n_len; r_dist <= n_dist;
                r_pos <= n_pos; r_st <= n_st; r_src <= n_src;
            end
            r_fwd <= i_go && put && (n_src == r_pos[AW-1:0]);
        end
        if (i_go) r_fwd_byte <= pbyte;
    end

    assign o_hist_req.wr_en   = i_go && put;
    assign o_hist_req.wr_byte = pbyte;
    assign o_wr_addr          = r_pos[AW-1:0];
    assign o_lit_byte         = (o_copy_step) ? cur_hist : pbyte;
    assign o_out_valid        = put;
    assign o_bit_acc          = acc;
    assign o_copy_pending     = (n_phase == PH_COPY);
    assign o_status           = n_st;
    assign o_bytes            = 25'({{(32-POSITION_BITS){1'b0}}, n_pos});
endmodule

/* rtl/core/deflate_fixed_huffman_inflate.sv */
// ----------------------------------------------------------------------------
// deflate_fixed_huffman_inflate
// Fixed-Huffman block decoder with a history window for copies.
// result: registered, valid in the cycle after the request is taken
// throughput: one request per cycle while the result channel is not stalled, at most one bit or one copied byte each
// the history read for the next copy byte is issued with the current request;
// distance one is served from a forward register
// reset: synchronous active low, capacity back to 65536, history not cleared
// ----------------------------------------------------------------------------
module deflate_fixed_huffman_inflate
    import dfi_pkg::*;
#(
    parameter int WINDOW_DEPTH  = WindowDepth,
    parameter int POSITION_BITS = PositionBits
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    dfi_in_if.sink    in_ch,
    dfi_out_if.source out_ch,
    dfi_cfg_if.sink   cfg_ch
);
    localparam int AW = $clog2(WINDOW_DEPTH);

    logic [CapBits-1:0] r_cap;
    logic               r_ov;
    logic               go;
    t_hist_req          hreq;
    logic [AW-1:0]      wa, ra;
    logic [7:0]         rd, ob;
    logic               step, ovl, acc, cp;
    logic [2:0]         st;
    logic [24:0]        bw;

    assign go           = in_ch.valid && in_ch.ready;
    assign in_ch.ready  = !r_ov || out_ch.ready;
    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CapReset;
            r_ov  <= 1'b0;
        end else begin
            if (cfg_ch.valid) r_cap <= cfg_ch.data;
            if (go) r_ov <= 1'b1;
            else if (out_ch.ready) r_ov <= 1'b0;
        end
        if (go) begin
            out_ch.out_byte      <= ovl ? ob : 8'd0;
            out_ch.out_valid     <= ovl;
            out_ch.bit_accepted  <= acc;
            out_ch.copy_pending  <= cp;
            out_ch.status        <= st;
            out_ch.bytes_written <= bw;
        end
    end
    assign out_ch.valid = r_ov;

    dfi_window #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_win (
        .i_clk(i_clk), .i_req(hreq), .i_wr_addr(wa), .i_rd_addr(ra), .o_rd_data(rd)
    );

    dfi_decoder #(.WINDOW_DEPTH(WINDOW_DEPTH), .POSITION_BITS(POSITION_BITS)) u_dec (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(go), .i_action(in_ch.action),
        .i_bit(in_ch.in_bit), .i_cap(r_cap), .i_hist_byte(rd), .o_hist_req(hreq),
        .o_wr_addr(wa), .o_rd_addr(ra), .o_copy_step(step), .o_lit_byte(ob),
        .o_out_valid(ovl), .o_bit_acc(acc), .o_copy_pending(cp), .o_status(st),
        .o_bytes(bw)
    );

    logic unused_step;
    assign unused_step = step;
endmodule

/* rtl/core/dfi_checker.sv */
// ----------------------------------------------------------------------------
// dfi_checker
// Port-level checks on the decoder's result channel.
// ----------------------------------------------------------------------------
module dfi_checker
    import dfi_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_byte_valid,
    input logic        i_bit_acc,
    input logic        i_copy_pending,
    input logic [2:0]  i_status,
    input logic [24:0] i_bytes
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_bytes))
        else $error("result dropped while stalled");
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_bit_acc && i_copy_pending && i_byte_valid))
        else $error("bit taken while copying");
    a_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status != ST_RUN |-> !i_copy_pending)
        else $error("copy pending after stop");
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_status <= ST_FULL)
        else $error("bad status");
endmodule

bind deflate_fixed_huffman_inflate dfi_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_out_valid(out_ch.valid),
    .i_out_ready(out_ch.ready), .i_byte_valid(out_ch.out_valid),
    .i_bit_acc(out_ch.bit_accepted), .i_copy_pending(out_ch.copy_pending),
    .i_status(out_ch.status), .i_bytes(out_ch.bytes_written)
);
